### rtl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the slot pool allocator: transaction
// payloads, operation and status codes and sequencer states.
// ----------------------------------------------------------------------------
package wsp_pkg;

   localparam int POOL_SLOTS_DEF = 32;
   localparam int MAX_RESULTS    = 32;
   localparam int SLOT_W         = 5;
   localparam int VALUE_W        = 32;
   localparam int OP_W           = 2;
   localparam int STATUS_W       = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_LIST    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_EXHAUSTED  = 2'd1,
      STAT_NOT_IN_USE = 2'd2,
      STAT_EMPTY      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_ALLOC,
      ST_REL_WALK,
      ST_REL_UNLINK,
      ST_REL_FREE,
      ST_LIST
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] watch_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [SLOT_W-1:0]         granted_slot;
      logic signed [VALUE_W-1:0] slot_value;
      logic                      last;
   } rsp_type;

endpackage

### rtl/watch_slot_pool_allocator_core.sv
// Sequence from the accepting edge: allocate passes through ST_ALLOC, list through
// ST_LIST with one result per cycle while the receiver takes them, and release walks
// the in-use list in ST_REL_WALK, one link table read per cycle, up to the slot (no
// walk when it is the head), then goes through ST_REL_UNLINK and ST_REL_FREE. One
// transaction at a time; the next is taken after the final result registers.
// Reset: lists restored at once through per-entry valid bits; stored values undefined.
// ----------------------------------------------------------------------------
// watch_slot_pool_allocator_core
// Fixed pool allocator with a LIFO free list and a newest-first in-use list
// kept as linked lists in one link table, walked by a small sequencer.
// ----------------------------------------------------------------------------
module watch_slot_pool_allocator_core
   import wsp_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LW    = $clog2(POOL_SLOTS + 1);
   localparam int IW    = $clog2(POOL_SLOTS);
   localparam int CW    = (LW > SLOT_W) ? LW : SLOT_W;
   localparam int CNT_W = $clog2(MAX_RESULTS);
   localparam logic [LW-1:0]    NONE_LINK = LW'(POOL_SLOTS);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_RESULTS - 1);

   state_type               state_ff, state_in;
   logic [LW-1:0]           free_head_ff, free_head_in;
   logic [LW-1:0]           used_head_ff, used_head_in;
   logic [LW-1:0]           ptr_ff, ptr_in;
   logic [LW-1:0]           prev_ff, prev_in;
   logic [LW-1:0]           target_ff, target_in;
   logic                    is_head_ff, is_head_in;
   status_type              code_ff, code_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   // link table: one write port, registered read, valid bit per entry
   logic [LW-1:0]           link_mem [POOL_SLOTS];
   logic [POOL_SLOTS-1:0]   link_vld_ff;
   logic [LW-1:0]           link_q_ff;
   logic [IW-1:0]           raddr_ff;
   logic [LW-1:0]           link_rd;
   logic                    lw_en;
   logic [LW-1:0]           lw_addr;
   logic [LW-1:0]           lw_data;

   logic signed [VALUE_W-1:0] val_mem [POOL_SLOTS];
   logic signed [VALUE_W-1:0] val_q_ff;
   logic                      vw_en;

   logic    out_free;
   logic    emit;
   rsp_type emit_data;
   logic    slot_ok;
   logic    list_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_ok   = CW'(req_data.slot) < CW'(POOL_SLOTS);
   // an entry never written holds its reset link, the next slot up
   assign link_rd   = link_vld_ff[raddr_ff] ? link_q_ff : (LW'(raddr_ff) + LW'(1));
   assign list_last = (link_rd == NONE_LINK) || (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         used_head_ff <= NONE_LINK;
         link_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         if (lw_en) begin
            link_vld_ff[lw_addr[IW-1:0]] <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      prev_ff    <= prev_in;
      target_ff  <= target_in;
      is_head_ff <= is_head_in;
      code_ff    <= code_in;
      value_ff   <= value_in;
      cnt_ff     <= cnt_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (lw_en) begin
         link_mem[lw_addr[IW-1:0]] <= lw_data;
      end
      link_q_ff <= link_mem[ptr_in[IW-1:0]];
      raddr_ff  <= ptr_in[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (vw_en) begin
         val_mem[ptr_ff[IW-1:0]] <= value_ff;
      end
      val_q_ff <= val_mem[ptr_in[IW-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      free_head_in = free_head_ff;
      used_head_in = used_head_ff;
      ptr_in       = ptr_ff;
      prev_in      = prev_ff;
      target_in    = target_ff;
      is_head_in   = is_head_ff;
      code_in      = code_ff;
      value_in     = value_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      lw_en        = 1'b0;
      lw_addr      = ptr_ff;
      lw_data      = used_head_ff;
      vw_en        = 1'b0;
      emit         = 1'b0;
      emit_data    = '{status: STAT_OK, granted_slot: SLOT_W'(ptr_ff),
                       slot_value: '0, last: 1'b1};

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            target_in = LW'(req_data.slot);
            value_in  = req_data.watch_value;
            if (req_valid) begin
               case (req_data.operation)
                  OP_ALLOC: begin
                     if (free_head_ff == NONE_LINK) begin
                        code_in  = STAT_EXHAUSTED;
                        state_in = ST_ERR;
                     end else begin
                        ptr_in   = free_head_ff;
                        state_in = ST_ALLOC;
                     end
                  end
                  OP_RELEASE: begin
                     if (!slot_ok || used_head_ff == NONE_LINK) begin
                        code_in  = STAT_NOT_IN_USE;
                        state_in = ST_ERR;
                     end else if (CW'(used_head_ff) == CW'(req_data.slot)) begin
                        ptr_in     = LW'(req_data.slot);
                        is_head_in = 1'b1;
                        state_in   = ST_REL_UNLINK;
                     end else begin
                        ptr_in     = used_head_ff;
                        is_head_in = 1'b0;
                        state_in   = ST_REL_WALK;
                     end
                  end
                  OP_LIST: begin
                     if (used_head_ff == NONE_LINK) begin
                        code_in  = STAT_EMPTY;
                        state_in = ST_ERR;
                     end else begin
                        ptr_in   = used_head_ff;
                        cnt_in   = '0;
                        state_in = ST_LIST;
                     end
                  end
                  default: begin
                     // reserved operation: dropped without a result
                  end
               endcase
            end
         end

         ST_ERR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{status: code_ff, granted_slot: '0, slot_value: '0, last: 1'b1};
               state_in  = ST_IDLE;
            end
         end

         ST_ALLOC: begin
            if (out_free) begin
               free_head_in = link_rd;
               lw_en        = 1'b1;
               lw_addr      = ptr_ff;
               lw_data      = used_head_ff;
               used_head_in = ptr_ff;
               vw_en        = 1'b1;
               emit         = 1'b1;
               emit_data    = '{status: STAT_OK, granted_slot: SLOT_W'(ptr_ff),
                                slot_value: value_ff, last: 1'b1};
               state_in     = ST_IDLE;
            end
         end

         ST_REL_WALK: begin
            // ptr holds the candidate predecessor, link_rd its successor
            if (link_rd == target_ff) begin
               prev_in  = ptr_ff;
               ptr_in   = target_ff;
               state_in = ST_REL_UNLINK;
            end else if (link_rd == NONE_LINK) begin
               code_in  = STAT_NOT_IN_USE;
               state_in = ST_ERR;
            end else begin
               ptr_in = link_rd;
            end
         end

         ST_REL_UNLINK: begin
            if (is_head_ff) begin
               used_head_in = link_rd;
            end else begin
               lw_en   = 1'b1;
               lw_addr = prev_ff;
               lw_data = link_rd;
            end
            state_in = ST_REL_FREE;
         end

         ST_REL_FREE: begin
            if (out_free) begin
               lw_en        = 1'b1;
               lw_addr      = ptr_ff;
               lw_data      = free_head_ff;
               free_head_in = ptr_ff;
               emit         = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_LIST: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{status: STAT_OK, granted_slot: SLOT_W'(ptr_ff),
                             slot_value: val_q_ff, last: list_last};
               if (list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = link_rd;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/wsp_checker.sv
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks on the slot pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module wsp_checker
   import wsp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result transaction stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // any real operation makes the sequencer busy, so req_ready is low after the accepting edge
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.operation == OP_ALLOC || req_data.operation == OP_RELEASE ||
       req_data.operation == OP_LIST)
      |=> !req_ready)
      else $error("accepted a new transaction while busy");

   // error results are single, zeroed and final
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK
      |-> rsp_data.last && rsp_data.granted_slot == '0 && rsp_data.slot_value == '0)
      else $error("malformed error result");

endmodule

bind watch_slot_pool_allocator_core wsp_checker u_wsp_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, release and list transactions into the slot pool
// allocator. A local model of the free and in-use lists predicts every
// result, and each result is checked field by field. Both sides of the
// handshake idle at random, and one long receiver stall fills the block.
// ----------------------------------------------------------------------------
module testbench;
   import wsp_pkg::*;

   localparam int         POOL        = POOL_SLOTS_DEF;
   localparam logic [5:0] NO_LINK     = 6'(POOL);
   localparam logic [1:0] OP_UNKNOWN  = 2'd3;
   localparam int         LONG_HOLD   = 200;
   localparam int         CYCLE_LIMIT = 600000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model of the pool
   logic [5:0]         pool_link [POOL];
   logic [5:0]         used_head;
   logic [5:0]         free_head;
   logic signed [31:0] pool_value [POOL];

   rsp_type pending_rsp [$];

   bit idle_on    = 1'b1;
   int hold_asked = 0;
   int hold_given = 0;
   int stall_left = 0;

   int cycle_count   = 0;
   int error_count   = 0;
   int checked_count = 0;
   int alloc_count   = 0;
   int release_count = 0;
   int list_count    = 0;
   int ignored_count = 0;

   watch_slot_pool_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // pool model
   // ------------------------------------------------------------------------
   function automatic void reset_pool();
      for (int i = 0; i < POOL; i++) begin
         pool_link[i]  = 6'(i + 1);
         pool_value[i] = '0;
      end
      used_head = NO_LINK;
      free_head = '0;
   endfunction

   function automatic int used_count();
      int         n;
      logic [5:0] pos;
      n   = 0;
      pos = used_head;
      while (pos != NO_LINK && n < POOL) begin
         n++;
         pos = pool_link[pos];
      end
      return n;
   endfunction

   function automatic logic [4:0] used_slot_at(input int k);
      logic [5:0] pos;
      pos = used_head;
      repeat (k) pos = pool_link[pos];
      return pos[4:0];
   endfunction

   function automatic void predict_pool(input req_type r);
      rsp_type    rs;
      logic [5:0] s;
      logic [5:0] prev;
      logic [5:0] pos;
      bit         found;
      int         n;
      rs      = '0;
      rs.last = 1'b1;
      case (r.operation)
         OP_ALLOC: begin
            if (free_head == NO_LINK) begin
               rs.status = STAT_EXHAUSTED;
            end else begin
               s                = free_head;
               free_head        = pool_link[s];
               pool_link[s]     = used_head;
               used_head        = s;
               pool_value[s]    = r.watch_value;
               rs.status        = STAT_OK;
               rs.granted_slot  = s[4:0];
               rs.slot_value    = r.watch_value;
            end
            pending_rsp.push_back(rs);
         end
         OP_RELEASE: begin
            s     = {1'b0, r.slot};
            found = 1'b0;
            if (used_head == s) begin
               used_head = pool_link[s];
               found     = 1'b1;
            end else begin
               prev = used_head;
               while (prev != NO_LINK && pool_link[prev] != s) prev = pool_link[prev];
               if (prev != NO_LINK) begin
                  pool_link[prev] = pool_link[s];
                  found           = 1'b1;
               end
            end
            if (found) begin
               pool_link[s]    = free_head;
               free_head       = s;
               rs.status       = STAT_OK;
               rs.granted_slot = s[4:0];
            end else begin
               rs.status = STAT_NOT_IN_USE;
            end
            pending_rsp.push_back(rs);
         end
         OP_LIST: begin
            pos = used_head;
            if (pos == NO_LINK) begin
               rs.status = STAT_EMPTY;
               pending_rsp.push_back(rs);
            end else begin
               n = 0;
               while (pos != NO_LINK && n < MAX_RESULTS) begin
                  rs.status       = STAT_OK;
                  rs.granted_slot = pos[4:0];
                  rs.slot_value   = pool_value[pos];
                  rs.last         = (pool_link[pos] == NO_LINK || n == MAX_RESULTS - 1);
                  pending_rsp.push_back(rs);
                  n++;
                  pos = pool_link[pos];
               end
            end
         end
         default: ;  // unknown operation: no result
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // result side: ready with random stall bursts, plus the long hold
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asked != hold_given) begin
         hold_given = hold_asked;
         stall_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, actual status %0d slot %0d value %0d last %0d",
                     $time, rsp_data.status, rsp_data.granted_slot, rsp_data.slot_value,
                     rsp_data.last);
         end else begin
            want = pending_rsp.pop_front();
            checked_count++;
            if (rsp_data.status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
            end
            if (rsp_data.granted_slot !== want.granted_slot) begin
               error_count++;
               $display("%0t: granted_slot expected %0d actual %0d", $time,
                        want.granted_slot, rsp_data.granted_slot);
            end
            if (rsp_data.slot_value !== want.slot_value) begin
               error_count++;
               $display("%0t: slot_value expected %0d actual %0d", $time,
                        want.slot_value, rsp_data.slot_value);
            end
            if (rsp_data.last !== want.last) begin
               error_count++;
               $display("%0t: last expected %0d actual %0d", $time, want.last,
                        rsp_data.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   function automatic req_type make_req(input logic [1:0] op, input logic [4:0] s,
                                        input logic [31:0] v);
      req_type r;
      r.operation   = op;
      r.slot        = s;
      r.watch_value = v;
      return r;
   endfunction

   task automatic send_req(input req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_pool(r);
      case (r.operation)
         OP_ALLOC:   alloc_count++;
         OP_RELEASE: release_count++;
         OP_LIST:    list_count++;
         default:    ignored_count++;
      endcase
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_cases();
      send_req(make_req(OP_LIST, 5'd0, 32'd0));              // empty listing
      send_req(make_req(OP_RELEASE, 5'd5, 32'd0));           // nothing in use
      send_req(make_req(OP_UNKNOWN, 5'd0, 32'd0));
      send_req(make_req(OP_ALLOC, 5'd31, 32'h8000_0000));
      send_req(make_req(OP_ALLOC, 5'd0, 32'h7fff_ffff));
      send_req(make_req(OP_ALLOC, 5'd0, 32'h0000_0000));
      send_req(make_req(OP_ALLOC, 5'd31, 32'hffff_ffff));
      send_req(make_req(OP_LIST, 5'd31, 32'hffff_ffff));
      send_req(make_req(OP_RELEASE, 5'd0, 32'hffff_ffff));   // tail of in-use list
      send_req(make_req(OP_RELEASE, 5'd2, 32'd0));           // middle
      send_req(make_req(OP_RELEASE, 5'd3, 32'd0));           // head
      send_req(make_req(OP_RELEASE, 5'd31, 32'd0));          // never allocated
      send_req(make_req(OP_RELEASE, 5'd2, 32'd0));           // already free
      send_req(make_req(OP_ALLOC, 5'd0, 32'h1234_5678));
      send_req(make_req(OP_LIST, 5'd0, 32'd0));
      send_req(make_req(OP_UNKNOWN, 5'd31, 32'hffff_ffff));
      send_req(make_req(OP_RELEASE, 5'd1, 32'd0));
      send_req(make_req(OP_RELEASE, 5'd3, 32'd0));
      send_req(make_req(OP_LIST, 5'd0, 32'd0));
      drain_responses();
   endtask

   // fill the whole pool, overrun it, list all slots, then empty it again
   task automatic test_pool_exhaustion();
      int k;
      while (used_count() < POOL)
         send_req(make_req(OP_ALLOC, 5'($urandom), $urandom));
      send_req(make_req(OP_ALLOC, 5'($urandom), $urandom));
      send_req(make_req(OP_ALLOC, 5'($urandom), $urandom));
      send_req(make_req(OP_LIST, 5'($urandom), $urandom));
      while (used_count() > 0) begin
         k = $urandom_range(0, used_count() - 1);
         send_req(make_req(OP_RELEASE, used_slot_at(k), $urandom));
         if ($urandom_range(0, 7) == 0)
            send_req(make_req(OP_LIST, 5'($urandom), $urandom));
      end
      send_req(make_req(OP_RELEASE, 5'($urandom), $urandom));
      send_req(make_req(OP_LIST, 5'($urandom), $urandom));
      drain_responses();
   endtask

   // receiver stalls for a long stretch while requests keep coming
   task automatic test_rsp_backpressure();
      hold_asked++;
      for (int i = 0; i < 14; i++) begin
         if (i % 4 == 3)
            send_req(make_req(OP_LIST, 5'($urandom), $urandom));
         else
            send_req(make_req(OP_ALLOC, 5'($urandom), $urandom));
      end
      drain_responses();
   endtask

   task automatic test_random_mix(input int count, input int quiet_tail);
      int used;
      int pick;
      int alloc_share;
      req_type r;
      for (int i = 0; i < count; i++) begin
         if (i == count - quiet_tail) idle_on = 1'b0;
         used        = used_count();
         pick        = $urandom_range(0, 99);
         alloc_share = (used < 8) ? 60 : (used > 28) ? 30 : 45;
         r           = make_req(OP_RELEASE, 5'($urandom), $urandom);
         if (pick < 3) begin
            r.operation = OP_UNKNOWN;
         end else if (pick < 12) begin
            r.operation = OP_LIST;
         end else if (pick < 12 + alloc_share) begin
            r.operation = OP_ALLOC;
         end else if (used > 0 && $urandom_range(0, 4) != 0) begin
            r.slot = used_slot_at($urandom_range(0, used - 1));
         end
         send_req(r);
      end
      drain_responses();
   endtask

   initial begin
      reset_pool();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_pool_exhaustion();
      test_rsp_backpressure();
      test_random_mix(210, 60);
      repeat (40) @(posedge clock);
      $display("covered %0d allocate, %0d release, %0d list and %0d ignored requests",
               alloc_count, release_count, list_count, ignored_count);
      $display("checked %0d results, %0d mismatches, %0d still waiting",
               checked_count, error_count, pending_rsp.size());
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
rtl/wsp_pkg.sv
rtl/watch_slot_pool_allocator_core.sv
rtl/wsp_checker.sv
tb/testbench.sv
